// ===== design/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg: shared types and constants for the cartridge bank controller
// Bus transfer payloads, region decode codes and register indexes.
// ----------------------------------------------------------------------------
package cbc_pkg;

	// bus access operation codes
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// address region codes (address bits 15:12)
	localparam logic [3:0] RGN_RAM_EN    = 4'h0;
	localparam logic [3:0] RGN_RAM_EN_HI = 4'h1;
	localparam logic [3:0] RGN_ROM_LO    = 4'h2;
	localparam logic [3:0] RGN_ROM_HI    = 4'h3;
	localparam logic [3:0] RGN_RAM_BANK  = 4'h4;
	localparam logic [3:0] RGN_RAM_BK_HI = 4'h5;
	localparam logic [3:0] RGN_SW_ROM_0  = 4'h6;
	localparam logic [3:0] RGN_SW_ROM_1  = 4'h7;
	localparam logic [3:0] RGN_CART_RAM  = 4'hA;
	localparam logic [3:0] RGN_CART_RAM1 = 4'hB;

	// configuration register indexes (paddr bit 2)
	localparam logic REG_BATTERY  = 1'b0;
	localparam logic REG_RAM_MASK = 1'b1;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// misc constants
	localparam logic [3:0] RAM_EN_KEY   = 4'hA;
	localparam logic [7:0] OPEN_BUS     = 8'hFF;
	localparam logic [7:0] ROM_BANK_RST = 8'h01;
	localparam logic [3:0] MASK_RST     = 4'hF;
	localparam int unsigned RAM_OFF_W   = 13;
	localparam int unsigned ROM_OFF_W   = 14;

	typedef struct packed {
		logic        operation;
		logic [15:0] address;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        rom_fetch;
		logic [22:0] rom_address;
		logic        save_request;
	} rsp_t;

endpackage

// ===== design/cbc_ram.sv =====
// ----------------------------------------------------------------------------
// cbc_ram: single-port cartridge RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module cbc_ram #(
	parameter int unsigned DEPTH = 131072,
	parameter int unsigned AW    = 17
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// write or read, read data valid in the next cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== design/cartridge_bank_controller.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_controller: bank controller for a handheld game cartridge
// Decodes CPU bus accesses, keeps the bank registers and cartridge RAM.
// ----------------------------------------------------------------------------
// Usage:
// - req channel: one bus access per transfer (operation, address, write_data).
// - rsp channel: exactly one result per access, in order.
// - APB port: battery_present at 0x0, ram_bank_mask at 0x4; write while idle.
// - A result passes through stage 1 (the synchronous RAM read) and the
//   output register before it shows on rsp.
// - Throughput: one access per cycle unless req_stall; the single RAM port
//   serves either the write or the read of the access taken in that cycle.
// - Bank registers update at the req transfer itself, so the next access
//   already sees them.
// - When rsp is stalled, the output register holds and one more access can
//   sit behind it; req_stall rises only when both are full.
// - Reset clears the bank registers (ROM bank 1, RAM off, not dirty) and the
//   pipeline; cartridge RAM content is not cleared and is undefined until
//   written.
// ----------------------------------------------------------------------------
module cartridge_bank_controller #(
	parameter int unsigned CART_PAGES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// apb configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cbc_pkg::PADDR_W-1:0]     paddr,
	input  logic [cbc_pkg::PDATA_W-1:0]     pwdata,
	output logic [cbc_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	// bus access channel
	input  logic                            req_valid,
	output logic                            req_stall,
	input  cbc_pkg::req_t                   req,
	// result channel
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output cbc_pkg::rsp_t                   rsp
);

	localparam int unsigned RAM_DEPTH = CART_PAGES * 8192;
	localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

	// configuration and bank registers
	logic       battery_q;
	logic [3:0] ram_mask_q;
	logic [7:0] rom_low_q;
	logic       rom_high_q;
	logic [3:0] ram_sel_q;
	logic       ram_en_q;
	logic       ram_dirty_q;

	// pipeline
	logic          v_s1;
	cbc_pkg::rsp_t res_s1;
	logic          use_ram_s1;
	logic          rsp_valid_q;
	cbc_pkg::rsp_t rsp_q;

	logic          cfg_wr;
	logic          req_acc;
	logic          s1_adv;
	logic [3:0]    rgn;
	logic          ram_key;
	logic          save_now;
	logic          ram_we;
	logic          ram_re;
	logic [3:0]    wrap_tbl [16];
	logic [3:0]    bank_wrap;
	logic [RAM_AW-1:0] ram_addr;
	logic [7:0]    ram_rdata;
	cbc_pkg::rsp_t res_d;
	logic          use_ram_d;

	// bank select wrap table, worked out at elaboration
	for (genvar g = 0; g < 16; g++) begin : g_wrap
		assign wrap_tbl[g] = 4'(g % CART_PAGES);
	end

	// apb access
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			cbc_pkg::REG_BATTERY:  prdata[0]   = battery_q;
			cbc_pkg::REG_RAM_MASK: prdata[3:0] = ram_mask_q;
			default:               prdata      = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			battery_q  <= 1'b0;
			ram_mask_q <= cbc_pkg::MASK_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				cbc_pkg::REG_BATTERY:  battery_q  <= pwdata[0];
				cbc_pkg::REG_RAM_MASK: ram_mask_q <= pwdata[3:0];
				default:               ;
			endcase
		end
	end

	// handshake: take a new access unless both stages are held
	assign s1_adv    = !rsp_valid_q || !rsp_stall;
	assign req_stall = v_s1 && !s1_adv;
	assign req_acc   = req_valid && !req_stall;

	// decode
	assign rgn       = req.address[15:12];
	assign ram_key   = (req.write_data[3:0] == cbc_pkg::RAM_EN_KEY);
	assign bank_wrap = wrap_tbl[ram_sel_q];
	assign ram_addr  = RAM_AW'({bank_wrap, req.address[cbc_pkg::RAM_OFF_W-1:0]});
	assign save_now  = req.operation == cbc_pkg::OP_WRITE
		&& (rgn == cbc_pkg::RGN_RAM_EN || rgn == cbc_pkg::RGN_RAM_EN_HI)
		&& battery_q && ram_en_q && !ram_key && ram_dirty_q;
	assign ram_we = req_acc && req.operation == cbc_pkg::OP_WRITE && ram_en_q
		&& (rgn == cbc_pkg::RGN_CART_RAM || rgn == cbc_pkg::RGN_CART_RAM1);
	assign ram_re = req_acc && req.operation == cbc_pkg::OP_READ && ram_en_q
		&& (rgn == cbc_pkg::RGN_CART_RAM || rgn == cbc_pkg::RGN_CART_RAM1);

	// result fields known at decode time
	always_comb begin
		res_d     = '0;
		use_ram_d = 1'b0;
		if (req.operation == cbc_pkg::OP_WRITE) begin
			res_d.save_request = save_now;
		end else begin
			case (rgn) inside
				cbc_pkg::RGN_RAM_EN, cbc_pkg::RGN_RAM_EN_HI,
				cbc_pkg::RGN_ROM_LO, cbc_pkg::RGN_ROM_HI: begin
					res_d.rom_fetch   = 1'b1;
					res_d.rom_address = 23'(req.address);
				end
				cbc_pkg::RGN_RAM_BANK, cbc_pkg::RGN_RAM_BK_HI,
				cbc_pkg::RGN_SW_ROM_0, cbc_pkg::RGN_SW_ROM_1: begin
					res_d.rom_fetch   = 1'b1;
					res_d.rom_address = {rom_high_q, rom_low_q,
						req.address[cbc_pkg::ROM_OFF_W-1:0]};
				end
				cbc_pkg::RGN_CART_RAM, cbc_pkg::RGN_CART_RAM1: begin
					use_ram_d       = ram_en_q;
					res_d.read_data = ram_en_q ? 8'h00 : cbc_pkg::OPEN_BUS;
				end
				default: res_d = '0;
			endcase
		end
	end

	// bank register updates at the req transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_low_q   <= cbc_pkg::ROM_BANK_RST;
			rom_high_q  <= 1'b0;
			ram_sel_q   <= '0;
			ram_en_q    <= 1'b0;
			ram_dirty_q <= 1'b0;
		end else if (req_acc && req.operation == cbc_pkg::OP_WRITE) begin
			case (rgn) inside
				cbc_pkg::RGN_RAM_EN, cbc_pkg::RGN_RAM_EN_HI: begin
					ram_en_q <= ram_key;
					if (save_now) begin
						ram_dirty_q <= 1'b0;
					end
				end
				cbc_pkg::RGN_ROM_LO:  rom_low_q  <= req.write_data;
				cbc_pkg::RGN_ROM_HI:  rom_high_q <= req.write_data[0];
				cbc_pkg::RGN_RAM_BANK, cbc_pkg::RGN_RAM_BK_HI:
					ram_sel_q <= req.write_data[3:0] & ram_mask_q;
				cbc_pkg::RGN_CART_RAM, cbc_pkg::RGN_CART_RAM1: begin
					if (ram_en_q) begin
						ram_dirty_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// cartridge ram
	cbc_ram #(
		.DEPTH (RAM_DEPTH),
		.AW    (RAM_AW)
	) u_ram (
		.clk   (clk),
		.en    (ram_we || ram_re),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (req.write_data),
		.rdata (ram_rdata)
	);

	// stage 1: waits for the ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_acc) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			res_s1     <= res_d;
			use_ram_s1 <= use_ram_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && v_s1) begin
			rsp_q <= res_s1;
			if (use_ram_s1) begin
				rsp_q.read_data <= ram_rdata;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (v_s1 && rsp_valid_q && rsp_stall))
		else $error("req stalled while pipeline has room");

	a_save_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && save_now) |=> !ram_dirty_q && !ram_en_q)
		else $error("save request left ram dirty or enabled");

	a_write_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> ram_dirty_q)
		else $error("ram write did not set dirty mark");

	a_save_only_write: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && res_s1.save_request) |-> (!res_s1.rom_fetch && !use_ram_s1))
		else $error("save request on a read result");

	a_ram_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("ram read and write in one cycle");

endmodule
